FILE: rtl/pfxev_pkg.sv
`timescale 1ns / 1ps

package pfxev_pkg;

  localparam int DATA_W = 32;

  // expression characters
  localparam logic [7:0] SYM_ADD  = 8'h2B;
  localparam logic [7:0] SYM_SUB  = 8'h2D;
  localparam logic [7:0] SYM_MUL  = 8'h2A;
  localparam logic [7:0] SYM_DIV  = 8'h2F;
  localparam logic [7:0] SYM_ZERO = 8'h30;

  // status codes, also used as the sticky error code
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNDER   = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_DIVZERO = 3'd3;
  localparam logic [2:0] ST_DIVOVF  = 3'd4;
  localparam logic [2:0] ST_EMPTY   = 3'd5;

  localparam logic [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic [7:0] symbol;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [2:0]               status;
  } out_item_t;

endpackage

FILE: rtl/pfxev_div.sv
`timescale 1ns / 1ps

module pfxev_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [pfxev_pkg::DATA_W-1:0] dividend,
  input  logic [pfxev_pkg::DATA_W-1:0] divisor,
  output logic                         done,
  output logic [pfxev_pkg::DATA_W-1:0] quotient
);
  import pfxev_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dvs;
  logic              neg;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_b;

  assign mag_a   = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
  assign mag_b   = divisor[DATA_W-1]  ? (~divisor + 1'b1)  : divisor;
  assign shifted = {rem, quo[DATA_W-1]};
  assign diff    = shifted - {1'b0, dvs};

  // one quotient bit a cycle, restoring
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= mag_a;
      rem <= '0;
      dvs <= mag_b;
      neg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy) begin
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? (~quo + 1'b1) : quo;

endmodule

FILE: rtl/postfix_expression_evaluator.sv
`timescale 1ns / 1ps

// postfix expression evaluator: takes one expression character per transfer and
// evaluates on a value stack of STACK_DEPTH 32-bit entries. the characters + - * /
// pop two values (the deeper one is the left operand) and push the wrapped result,
// division truncating toward zero; any other byte pushes (byte - '0') as a signed
// 8-bit value sign-extended to 32 bits. the transfer marked is_last yields one
// result: the top of stack (0 when empty) and a status (sticky first error, else
// empty or ok), after which stack and error are cleared. the top of stack lives in
// a register and the rest in a single-port-read memory whose read is registered.
// an operand is pushed from idle; +, - and * go through an operator state for the
// memory read of the deeper value; a regular division then waits on the divider,
// one quotient bit a cycle. a last character then loads the result register in an
// emit state, waiting while the old result is untaken. no clearing pass after reset.

module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pfxev_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pfxev_pkg::out_item_t out_data
);
  import pfxev_pkg::*;

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_OPER,
    S_DIVW,
    S_EMIT
  } state_t;

  state_t            state;
  logic [SPW-1:0]    sp;        // count of held values
  logic [2:0]        err;       // sticky first error
  logic [DATA_W-1:0] top;       // cached top of stack
  logic [7:0]        op;
  logic              last;

  // entries below the top of stack
  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_data;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic              wr_en;

  logic              in_xfer;
  logic              is_op;
  logic [SPW-1:0]    sp_m1;
  logic [SPW-1:0]    sp_m2;
  logic [7:0]        operand_byte;
  logic [DATA_W-1:0] operand;
  logic [DATA_W-1:0] alu_res;
  logic              div_zero;
  logic              div_ovf;
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_quo;
  logic              emit_load;
  state_t            after_item;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    case (in_data.symbol)
      SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV: is_op = 1'b1;
      default:                            is_op = 1'b0;
    endcase
  end

  assign sp_m1        = sp - SPW'(1);
  assign sp_m2        = sp - SPW'(2);
  assign rd_addr      = sp_m2[AW-1:0];
  assign wr_addr      = sp_m1[AW-1:0];
  assign operand_byte = in_data.symbol - SYM_ZERO;
  assign operand      = {{(DATA_W-8){operand_byte[7]}}, operand_byte};

  // push spills the old top into the memory unless the stack was empty or full
  assign wr_en = in_xfer && !is_op && (sp < SPW'(STACK_DEPTH)) && (sp != '0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= top;
    end
    rd_data <= mem[rd_addr];
  end

  // operator stage: left from memory, right from the cached top
  always_comb begin
    case (op)
      SYM_ADD: alu_res = rd_data + top;
      SYM_SUB: alu_res = rd_data - top;
      SYM_MUL: alu_res = rd_data * top;
      default: alu_res = '0;
    endcase
  end

  assign div_zero  = (top == '0);
  assign div_ovf   = (rd_data == INT_MIN) && (top == '1);
  assign div_start = (state == S_OPER) && (op == SYM_DIV) && !div_zero && !div_ovf;

  pfxev_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rd_data),
    .divisor  (top),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign emit_load  = (state == S_EMIT) && (!out_valid || !out_stall);
  assign after_item = last ? S_EMIT : S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sp        <= '0;
      err       <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      // a result load in the same cycle sets valid again below
      if (out_valid && !out_stall && !emit_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            op   <= in_data.symbol;
            last <= in_data.is_last;
            if (is_op) begin
              if (sp < SPW'(2)) begin
                if (err == ST_OK) begin
                  err <= ST_UNDER;
                end
                state <= in_data.is_last ? S_EMIT : S_IDLE;
              end else begin
                // deeper value is being read this edge
                state <= S_OPER;
              end
            end else begin
              if (sp < SPW'(STACK_DEPTH)) begin
                top <= operand;
                sp  <= sp + SPW'(1);
              end else if (err == ST_OK) begin
                err <= ST_FULL;
              end
              state <= in_data.is_last ? S_EMIT : S_IDLE;
            end
          end
        end
        S_OPER: begin
          if (op == SYM_DIV) begin
            if (div_zero) begin
              if (err == ST_OK) begin
                err <= ST_DIVZERO;
              end
              top   <= '0;
              sp    <= sp_m1;
              state <= after_item;
            end else if (div_ovf) begin
              if (err == ST_OK) begin
                err <= ST_DIVOVF;
              end
              top   <= INT_MIN;
              sp    <= sp_m1;
              state <= after_item;
            end else begin
              state <= S_DIVW;
            end
          end else begin
            top   <= alu_res;
            sp    <= sp_m1;
            state <= after_item;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            top   <= div_quo;
            sp    <= sp_m1;
            state <= after_item;
          end
        end
        S_EMIT: begin
          // waits here while the previous result is still held under a stall
          if (emit_load) begin
            out_valid      <= 1'b1;
            out_data.value <= (sp != '0) ? top : '0;
            if (err != ST_OK) begin
              out_data.status <= err;
            end else if (sp == '0) begin
              out_data.status <= ST_EMPTY;
            end else begin
              out_data.status <= ST_OK;
            end
            sp    <= '0;
            err   <= ST_OK;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // stack never holds more than its depth
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SPW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // the divider reports only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIVW))
    else $error("divider result with no division pending");

  // loading a result clears the stack and the sticky error
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    emit_load |=> (sp == '0) && (err == ST_OK) && out_valid)
    else $error("result load did not clear the stack");

  // an operator only reaches the memory stage with two values held
  a_oper_depth: assert property (@(posedge clk) disable iff (rst)
    (state == S_OPER) |-> (sp >= SPW'(2)))
    else $error("operator stage with fewer than two values");

endmodule
